// ----- rtl/quinary_huffman_code_packer_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quinary Huffman code packer
// Concurrent property wrappers sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUINARY_HUFFMAN_CODE_PACKER_TOP_MACROS_SVH
`define QUINARY_HUFFMAN_CODE_PACKER_TOP_MACROS_SVH

// Same-cycle implication
`define QHCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QHCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qhcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhcp_pkg
// Shared constants, types and helpers of the quinary Huffman code packer.
// ----------------------------------------------------------------------------
package qhcp_pkg;

  localparam int SYMBOLS            = 256;
  localparam int SYM_W              = 8;
  localparam int LEN_W              = 5;
  localparam int DIGIT_BITS         = 3;
  localparam int FIELD_DIGITS       = 16;
  localparam int DIGIT_FIELD_W      = FIELD_DIGITS * DIGIT_BITS;
  localparam int BYTE_W             = 8;
  localparam int PEND_W             = 3;
  localparam int DEFAULT_MAX_DIGITS = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic                     wr_en;
    logic                     rd_en;
    logic [SYM_W-1:0]         addr;
    logic [LEN_W-1:0]         len;
    logic [DIGIT_FIELD_W-1:0] digits;
  } tbl_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]         len;
    logic [DIGIT_FIELD_W-1:0] digits;
  } tbl_entry_t;

  // Digits 5 to 7 all go out as 7
  function automatic logic [DIGIT_BITS-1:0] map_digit(input logic [DIGIT_BITS-1:0] d);
    map_digit = (d > 3'd4) ? 3'd7 : d;
  endfunction

endpackage

// ----- rtl/quinary_huffman_code_packer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quinary_huffman_code_packer_top
// Emit stage of a 5-ary Huffman coder: code table, bit packer, byte output.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   input   | in_valid / in_ready  | in_op, in_symbol, in_code_length,
//           |                      | in_code_digits
//   result  | out_valid / out_ready| out_byte, out_last
//
// Load writes the table without leaving idle. Flush goes through the flush state
// only when a partial byte is pending. Encode passes through the table's
// registered read, then the byte shifter that sends one byte per cycle.
// Reset clears the table's valid bits at once; no clearing sweep.
// A full output register with out_ready low holds the byte shifter.
// ----------------------------------------------------------------------------
module quinary_huffman_code_packer_top #(
  parameter int MAX_DIGITS = qhcp_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [qhcp_pkg::SYM_W-1:0]          in_symbol,
  input  logic [qhcp_pkg::LEN_W-1:0]          in_code_length,
  input  logic [qhcp_pkg::DIGIT_FIELD_W-1:0]  in_code_digits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qhcp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_last
);
  import qhcp_pkg::*;

  tbl_cmd_t   tbl_cmd;
  tbl_entry_t tbl_entry;

  qhcp_table #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .tbl_cmd   (tbl_cmd),
    .tbl_entry (tbl_entry)
  );

  qhcp_packer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_packer (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_symbol      (in_symbol),
    .in_code_length (in_code_length),
    .in_code_digits (in_code_digits),
    .tbl_cmd        (tbl_cmd),
    .tbl_entry      (tbl_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

endmodule

// ----- rtl/qhcp_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhcp_table
// Code table memory: one write or one registered read per cycle, with a
// valid bit per entry so that unwritten entries read as zero length.
// ----------------------------------------------------------------------------
module qhcp_table #(
  parameter int MAX_DIGITS = qhcp_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qhcp_pkg::tbl_cmd_t   tbl_cmd,
  output qhcp_pkg::tbl_entry_t tbl_entry
);
  import qhcp_pkg::*;

  localparam int CAP     = (MAX_DIGITS > FIELD_DIGITS) ? FIELD_DIGITS : MAX_DIGITS;
  localparam int DIGIT_W = CAP * DIGIT_BITS;
  localparam int WORD_W  = LEN_W + DIGIT_W;

  logic [WORD_W-1:0]  mem [SYMBOLS];
  logic [SYMBOLS-1:0] valid_r;
  logic [WORD_W-1:0]  rd_word_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (tbl_cmd.wr_en) begin
      mem[tbl_cmd.addr] <= {tbl_cmd.len, tbl_cmd.digits[DIGIT_W-1:0]};
    end
    if (tbl_cmd.rd_en) begin
      rd_word_r <= mem[tbl_cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (tbl_cmd.wr_en) begin
        valid_r[tbl_cmd.addr] <= 1'b1;
      end
      if (tbl_cmd.rd_en) begin
        rd_valid_r <= valid_r[tbl_cmd.addr];
      end
    end
  end

  // An entry never written reads as an empty code
  assign tbl_entry.len    = rd_valid_r ? rd_word_r[WORD_W-1 -: LEN_W] : '0;
  assign tbl_entry.digits = DIGIT_FIELD_W'(rd_word_r[DIGIT_W-1:0]);

endmodule

// ----- rtl/qhcp_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhcp_packer
// Sequencer with one shift unit: merges the pending bits with the looked-up
// code, then peels off one byte per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module qhcp_packer #(
  parameter int MAX_DIGITS = qhcp_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [qhcp_pkg::SYM_W-1:0]          in_symbol,
  input  logic [qhcp_pkg::LEN_W-1:0]          in_code_length,
  input  logic [qhcp_pkg::DIGIT_FIELD_W-1:0]  in_code_digits,
  output qhcp_pkg::tbl_cmd_t                  tbl_cmd,
  input  qhcp_pkg::tbl_entry_t                tbl_entry,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qhcp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_last
);
  import qhcp_pkg::*;

  localparam int CAP      = (MAX_DIGITS > FIELD_DIGITS) ? FIELD_DIGITS : MAX_DIGITS;
  localparam int DIGIT_W  = CAP * DIGIT_BITS;
  localparam int STREAM_W = DIGIT_W + BYTE_W - 1;
  localparam int CNT_W    = $clog2(STREAM_W + 1);
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STREAM_W-1:0] stream_r, stream_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BYTE_W-1:0]   pend_byte_r, pend_byte_nxt;
  logic [PEND_W-1:0]   pend_bits_r, pend_bits_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_fire;
  logic                slot_free;
  logic [DIGIT_W-1:0]  code_bits;
  logic [STREAM_W-1:0] stream_shr;
  logic [CNT_W-1:0]    count_rem;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Table access straight from the input transaction
  always_comb begin
    tbl_cmd.wr_en  = in_fire && (in_op == OP_LOAD);
    tbl_cmd.rd_en  = in_fire && (in_op == OP_ENCODE);
    tbl_cmd.addr   = in_symbol;
    tbl_cmd.len    = (in_code_length > CAP_LEN) ? CAP_LEN : in_code_length;
    tbl_cmd.digits = in_code_digits;
  end

  // Map digits and drop those past the code length
  always_comb begin
    code_bits = '0;
    for (int i = 0; i < CAP; i++) begin
      if (LEN_W'(i) < tbl_entry.len) begin
        code_bits[i*DIGIT_BITS +: DIGIT_BITS] =
          map_digit(tbl_entry.digits[i*DIGIT_BITS +: DIGIT_BITS]);
      end
    end
  end

  assign stream_shr = stream_r >> BYTE_W;
  assign count_rem  = count_r - CNT_W'(BYTE_W);

  always_comb begin
    state_nxt     = state_r;
    stream_nxt    = stream_r;
    count_nxt     = count_r;
    pend_byte_nxt = pend_byte_r;
    pend_bits_nxt = pend_bits_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_ENCODE) begin
            state_nxt = ST_READ;
          end else if (in_op == OP_FLUSH && pend_bits_r != '0) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_READ: begin
        // Append the code above the pending bits
        stream_nxt = STREAM_W'(pend_byte_r) | (STREAM_W'(code_bits) << pend_bits_r);
        count_nxt  = CNT_W'(pend_bits_r) + CNT_W'(tbl_entry.len) * CNT_W'(DIGIT_BITS);
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (count_r < CNT_W'(BYTE_W)) begin
          pend_byte_nxt = stream_r[BYTE_W-1:0];
          pend_bits_nxt = count_r[PEND_W-1:0];
          state_nxt     = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = stream_r[BYTE_W-1:0];
          out_last_nxt  = (count_rem < CNT_W'(BYTE_W));
          stream_nxt    = stream_shr;
          count_nxt     = count_rem;
          if (count_rem < CNT_W'(BYTE_W)) begin
            pend_byte_nxt = stream_shr[BYTE_W-1:0];
            pend_bits_nxt = count_rem[PEND_W-1:0];
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_byte_r;
          out_last_nxt  = 1'b1;
          pend_byte_nxt = '0;
          pend_bits_nxt = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_byte_r <= '0;
      pend_bits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_bits_r <= pend_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stream_r   <= stream_nxt;
    count_r    <= count_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/qhcp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhcp_checker
// Port-level checks on the packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "quinary_huffman_code_packer_top_macros.svh"

module qhcp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [1:0]                          in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [qhcp_pkg::BYTE_W-1:0]         out_byte,
  input logic                                out_last
);
  import qhcp_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // Hold a stalled result transaction
  `QHCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_byte) && $stable(out_last),
                    "result changed while stalled")
  // Encode blocks the input while the table is read
  `QHCP_ASSERT_NEXT(a_encode_busy, in_fire && in_op == OP_ENCODE, !in_ready,
                    "input ready during table read")
  // Load completes in its own cycle
  `QHCP_ASSERT_NEXT(a_load_single, in_fire && in_op == OP_LOAD, in_ready,
                    "load held the input")
  // Idle without transactions stays idle
  `QHCP_ASSERT_NEXT(a_idle_stays, in_ready && !in_valid, in_ready,
                    "ready dropped with no transaction")

endmodule

bind quinary_huffman_code_packer_top qhcp_checker u_qhcp_checker (.*);
